// ===== hdl/spe_pkg.sv =====
// shared constants, opcodes and transaction types for the spike priority encoder
`default_nettype none
package spe_pkg;

	localparam int NUM_CHANNELS = 64;
	localparam int ADDRESS_BITS = 6;
	localparam int CH_IDX_BITS  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	localparam logic [1:0] OP_SPIKE = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_NOP   = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [5:0] channel;
		logic [5:0] target_addr;
	} item_t;

	typedef struct packed {
		logic       spike_accepted;
		logic       spike_lost;
		logic       emit_valid;
		logic [5:0] emit_address;
	} result_t;

	typedef logic [CH_IDX_BITS-1:0]  ch_idx_t;
	typedef logic [ADDRESS_BITS-1:0] naddr_t;

	// requests from the top level to the pending flag store
	typedef struct packed {
		ch_idx_t query_idx;
		logic    set_en;
		logic    clr_en;
		ch_idx_t clr_idx;
	} pend_ctrl_t;

	typedef struct packed {
		logic    hit;
		logic    any;
		ch_idx_t first;
	} pend_stat_t;

endpackage
`default_nettype wire

// ===== hdl/spe_pend_enc.sv =====
// pending flag register with lowest-channel-first priority encoder
`default_nettype none
module spe_pend_enc (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire spe_pkg::pend_ctrl_t ctrl,
	output spe_pkg::pend_stat_t     stat
);

	logic [spe_pkg::NUM_CHANNELS-1:0] flags_q;
	logic [spe_pkg::NUM_CHANNELS-1:0] lowest;
	spe_pkg::ch_idx_t                 first;

	// isolate the lowest set flag, then or-encode its position
	always_comb begin
		lowest = flags_q & (~flags_q + 1'b1);
		first  = '0;
		for (int i = 0; i < spe_pkg::NUM_CHANNELS; i++) begin
			if (lowest[i]) begin
				first = first | spe_pkg::CH_IDX_BITS'(i);
			end
		end
	end

	assign stat.hit   = flags_q[ctrl.query_idx];
	assign stat.any   = |flags_q;
	assign stat.first = first;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else begin
			if (ctrl.set_en) begin
				flags_q[ctrl.query_idx] <= 1'b1;
			end
			if (ctrl.clr_en) begin
				flags_q[ctrl.clr_idx] <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== hdl/spe_addr_table.sv =====
// channel to neuron address table, synchronous memory with identity default
`default_nettype none
module spe_addr_table (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             wr_en,
	input  wire spe_pkg::ch_idx_t wr_idx,
	input  wire spe_pkg::naddr_t  wr_data,
	input  wire logic             rd_en,
	input  wire spe_pkg::ch_idx_t rd_idx,
	output spe_pkg::naddr_t       rd_data
);

	spe_pkg::naddr_t                  mem [spe_pkg::NUM_CHANNELS];
	logic [spe_pkg::NUM_CHANNELS-1:0] written_q;
	spe_pkg::naddr_t                  rdata_q;
	logic                             rvalid_q;
	spe_pkg::ch_idx_t                 ridx_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_idx];
			ridx_q  <= rd_idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
			rvalid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_idx] <= 1'b1;
			end
			if (rd_en) begin
				rvalid_q <= written_q[rd_idx];
			end
		end
	end

	// entries never written read as their own index
	assign rd_data = rvalid_q ? rdata_q : spe_pkg::ADDRESS_BITS'(ridx_q);

endmodule
`default_nettype wire

// ===== hdl/spike_priority_encoder_unit.sv =====
// spike priority encoder top level
// Usage: one input channel (item_valid / item_stall / item) carries spike,
// tick and table-write transactions; one output channel (result_valid /
// result_stall / result) returns exactly one result per input transaction.
// Result: the result is registered and appears in the cycle after the input
// transaction is taken.
// Throughput: one transaction per cycle while item_stall is low. A tick that
// loads the output buffer starts a read of the address table; the read data
// lands in the next cycle and is forwarded to a tick in that cycle, so the
// table's single read port sets no gap between transactions.
// Reset: pending flags, buffer-full flag and table valid bits clear at once;
// the table then reads as the identity map until entries are written. No
// clearing pass is needed, the block takes transactions right after reset.
// Stall: while a result waits under result_stall, item_stall is raised and
// the result holds; with the result slot free, input is taken every cycle.
`default_nettype none
module spike_priority_encoder_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire spe_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output spe_pkg::result_t      result
);

	logic                accept;
	logic                is_spike, is_tick, is_write, ch_ok;
	logic                tick_emit, tick_load;
	spe_pkg::ch_idx_t    ch_idx;
	spe_pkg::pend_ctrl_t pctrl;
	spe_pkg::pend_stat_t pstat;
	spe_pkg::naddr_t     tbl_rd_data;
	spe_pkg::naddr_t     buf_val;
	spe_pkg::result_t    result_d;

	logic                full_q;
	logic                load_s1;
	spe_pkg::naddr_t     buffer_q;
	logic                result_valid_q;
	spe_pkg::result_t    result_q;

	assign item_stall = result_valid_q & result_stall;
	assign accept     = item_valid & ~item_stall;

	assign ch_idx   = spe_pkg::CH_IDX_BITS'(item.channel);
	assign ch_ok    = 32'(item.channel) < 32'(spe_pkg::NUM_CHANNELS);
	assign is_spike = item.opcode == spe_pkg::OP_SPIKE;
	assign is_tick  = item.opcode == spe_pkg::OP_TICK;
	assign is_write = item.opcode == spe_pkg::OP_WRITE;

	assign tick_emit = is_tick & full_q;
	assign tick_load = is_tick & ~full_q & pstat.any;

	// table data still in flight is forwarded to an emitting tick
	assign buf_val = load_s1 ? tbl_rd_data : buffer_q;

	always_comb begin
		pctrl.query_idx = ch_idx;
		pctrl.set_en    = accept & is_spike & ch_ok & ~pstat.hit;
		pctrl.clr_en    = accept & tick_load;
		pctrl.clr_idx   = pstat.first;
	end

	spe_pend_enc u_pend (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (pctrl),
		.stat   (pstat)
	);

	spe_addr_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (accept & is_write & ch_ok),
		.wr_idx  (ch_idx),
		.wr_data (spe_pkg::ADDRESS_BITS'(item.target_addr)),
		.rd_en   (accept & tick_load),
		.rd_idx  (pstat.first),
		.rd_data (tbl_rd_data)
	);

	always_comb begin
		result_d.spike_accepted = is_spike & ch_ok & ~pstat.hit;
		result_d.spike_lost     = is_spike & ch_ok & pstat.hit;
		result_d.emit_valid     = tick_emit;
		result_d.emit_address   = tick_emit ? 6'(buf_val) : 6'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q         <= 1'b0;
			load_s1        <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			load_s1 <= accept & tick_load;
			if (accept & tick_emit) begin
				full_q <= 1'b0;
			end else if (accept & tick_load) begin
				full_q <= 1'b1;
			end
			if (accept) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			buffer_q <= tbl_rd_data;
		end
		if (accept) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
`default_nettype wire

// ===== hdl/spe_checker.sv =====
// port-level checks for the spike priority encoder, bound to the top level
`default_nettype none
module spe_checker (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             item_valid,
	input wire logic             item_stall,
	input wire logic             result_valid,
	input wire logic             result_stall,
	input wire spe_pkg::result_t result
);

	// a result reports one kind of event at most
	a_one_event: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $onehot0({result.spike_accepted, result.spike_lost,
			result.emit_valid}))
		else $error("result reports more than one event");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.emit_valid) |-> (result.emit_address == 6'd0))
		else $error("emit address set without emission");

	// input is held back only by a waiting result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall))
		else $error("input stalled without a stalled result");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall) |=> result_valid)
		else $error("accepted transaction produced no result");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("stalled result changed");

endmodule

bind spike_priority_encoder_unit spe_checker u_spe_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);
`default_nettype wire

// ===== bench/tb_spike_priority_encoder_unit.sv =====
// testbench for the spike priority encoder: queued stimulus, clocked driver and monitor
`timescale 1ns / 100ps
module tb_spike_priority_encoder_unit;

	typedef struct {
		spe_pkg::item_t txn;
		int unsigned    gap;
	} stim_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_stall;
	spe_pkg::item_t   item = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	spe_pkg::result_t result;

	stim_t            stim_q[$];
	spe_pkg::result_t expect_q[$];
	logic             in_taken = 1'b0;
	int unsigned      gap_left = 0;
	int unsigned      hold_left = 0;
	int               err_count = 0;

	// shadow copy of the encoder state
	logic [spe_pkg::NUM_CHANNELS-1:0] pend_flags;
	spe_pkg::naddr_t                  addr_map[spe_pkg::NUM_CHANNELS];
	spe_pkg::naddr_t                  obuf;
	logic                             obuf_full;

	spike_priority_encoder_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item(item),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result(result)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic spe_pkg::result_t encode_step(input spe_pkg::item_t t);
		spe_pkg::result_t r;
		int               n;
		r = '0;
		case (t.opcode)
			spe_pkg::OP_SPIKE: begin
				if (pend_flags[t.channel]) begin
					r.spike_lost = 1'b1;
				end else begin
					pend_flags[t.channel] = 1'b1;
					r.spike_accepted = 1'b1;
				end
			end
			spe_pkg::OP_TICK: begin
				if (obuf_full) begin
					r.emit_valid = 1'b1;
					r.emit_address = obuf;
					obuf_full = 1'b0;
				end else begin
					// lowest-numbered pending channel wins
					for (n = 0; n < spe_pkg::NUM_CHANNELS; n++) begin
						if (!obuf_full && pend_flags[n]) begin
							obuf = addr_map[n];
							obuf_full = 1'b1;
							pend_flags[n] = 1'b0;
						end
					end
				end
			end
			spe_pkg::OP_WRITE: begin
				addr_map[t.channel] = t.target_addr;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 3);
		if (r < 92)
			return $urandom_range(4, 8);
		return $urandom_range(20, 60);
	endfunction

	task automatic add_item(input logic [1:0] op, input int ch, input int na,
				input int unsigned gap);
		stim_t s;
		s.txn = '{opcode: op, channel: ch[5:0], target_addr: na[5:0]};
		s.gap = gap;
		stim_q.push_back(s);
	endtask

	task automatic check_field(input string name, input int exp_v, input int act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
			err_count++;
		end
	endtask

	// input side: predict on every accepted transaction
	always @(posedge clk) begin
		if (arst_n && item_valid && !item_stall)
			expect_q.push_back(encode_step(item));
		in_taken <= arst_n && item_valid && !item_stall;
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && (!item_valid || in_taken)) begin
			if (gap_left > 0) begin
				item_valid <= 1'b0;
				gap_left = gap_left - 1;
			end else if (stim_q.size() > 0) begin
				item <= stim_q[0].txn;
				gap_left = stim_q[0].gap;
				void'(stim_q.pop_front());
				item_valid <= 1'b1;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver back-pressure, with occasional long stall-free stretches
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left > 0) begin
				hold_left = hold_left - 1;
			end else if (result_stall) begin
				result_stall <= 1'b0;
				hold_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
					: $urandom_range(0, 6);
			end else begin
				result_stall <= 1'b1;
				hold_left = idle_len() - 1;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expect_q.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %h", $time, result);
				err_count++;
			end else begin
				check_field("spike_accepted", expect_q[0].spike_accepted,
					result.spike_accepted);
				check_field("spike_lost", expect_q[0].spike_lost, result.spike_lost);
				check_field("emit_valid", expect_q[0].emit_valid, result.emit_valid);
				check_field("emit_address", expect_q[0].emit_address, result.emit_address);
				void'(expect_q.pop_front());
			end
		end
	end

	initial begin
		int          n;
		int          real_cnt;
		int          idx;
		int unsigned spike_pct;
		int unsigned r;
		int          ch;
		bit          quiet;
		logic [1:0]  op;

		pend_flags = '0;
		obuf = '0;
		obuf_full = 1'b0;
		for (n = 0; n < spe_pkg::NUM_CHANNELS; n++)
			addr_map[n] = n[spe_pkg::ADDRESS_BITS-1:0];

		// directed part
		add_item(spe_pkg::OP_TICK, 0, 0, 0);     // tick with nothing pending
		add_item(spe_pkg::OP_NOP, 63, 63, 0);
		add_item(spe_pkg::OP_SPIKE, 63, 63, 0);
		add_item(spe_pkg::OP_SPIKE, 63, 0, 0);   // lost spike
		add_item(spe_pkg::OP_SPIKE, 0, 0, 0);
		add_item(spe_pkg::OP_WRITE, 0, 63, 0);
		add_item(spe_pkg::OP_WRITE, 63, 0, 0);
		add_item(spe_pkg::OP_TICK, 0, 0, 0);     // loads buffer from channel 0
		add_item(spe_pkg::OP_TICK, 63, 63, 0);   // emits
		add_item(spe_pkg::OP_TICK, 0, 0, 0);
		add_item(spe_pkg::OP_TICK, 0, 0, 0);
		add_item(spe_pkg::OP_TICK, 0, 0, 0);     // empty again
		add_item(spe_pkg::OP_WRITE, 21, 42, 0);
		add_item(spe_pkg::OP_WRITE, 42, 21, 0);
		add_item(spe_pkg::OP_SPIKE, 42, 63, 0);
		add_item(spe_pkg::OP_SPIKE, 21, 0, 0);
		add_item(spe_pkg::OP_SPIKE, 42, 0, 0);
		add_item(spe_pkg::OP_TICK, 0, 0, 0);
		add_item(spe_pkg::OP_SPIKE, 21, 0, 0);   // re-armed after being taken
		add_item(spe_pkg::OP_TICK, 0, 0, 0);
		add_item(spe_pkg::OP_TICK, 0, 0, 0);
		add_item(spe_pkg::OP_TICK, 0, 0, 0);
		add_item(spe_pkg::OP_TICK, 0, 0, 0);
		add_item(spe_pkg::OP_TICK, 0, 0, 0);

		// random part, in segments of differing spike density
		real_cnt = 0;
		idx = 0;
		spike_pct = 50;
		quiet = 1'b0;
		while (real_cnt < 1900) begin
			if (idx % 100 == 0) begin
				case ($urandom_range(0, 3))
					0: spike_pct = 20;
					1: spike_pct = 45;
					2: spike_pct = 70;
					default: spike_pct = 90;
				endcase
				quiet = ($urandom_range(0, 4) == 0);
			end
			r = $urandom_range(0, 99);
			if (r < 4)
				op = spe_pkg::OP_NOP;
			else if (r < 10)
				op = spe_pkg::OP_WRITE;
			else if ($urandom_range(0, 99) < spike_pct)
				op = spe_pkg::OP_SPIKE;
			else
				op = spe_pkg::OP_TICK;
			// a hot group of low channels makes lost spikes and contention likely
			ch = $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(0, 63);
			add_item(op, ch, $urandom_range(0, 63),
				(!quiet && $urandom_range(0, 3) == 0) ? idle_len() : 0);
			if (op != spe_pkg::OP_NOP)
				real_cnt++;
			idx++;
		end

		repeat (3) @(negedge clk);
		arst_n = 1'b1;

		while (stim_q.size() != 0 || item_valid || expect_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#10ms;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/spe_pkg.sv
hdl/spe_pend_enc.sv
hdl/spe_addr_table.sv
hdl/spike_priority_encoder_unit.sv
hdl/spe_checker.sv
bench/tb_spike_priority_encoder_unit.sv
